FILE: hdl/bfra_pkg.sv
// Shared types and constants of the bitmap free-run allocator.
// Used by bfra_run_track and bitmap_free_run_allocator; depends on nothing.
package bfra_pkg;

  // Bitmap memory row and the slice the run tracker consumes per cycle
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WORD_AW   = 5;
  localparam int unsigned SLICE_W   = 8;
  localparam int unsigned SLICE_AW  = 3;
  localparam int unsigned SLICE_SEL_W = WORD_AW - SLICE_AW;

  // Configuration port
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned START_W   = 10;
  localparam int unsigned INDEX_W   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENTRIES = 2'd2;

  // Fit policies; the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Request operations
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Sequencer to run tracker control
  typedef struct packed {
    logic clear;
    logic step;
    logic best;
    logic worst;
  } trk_ctrl_t;

endpackage

FILE: hdl/bfra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bfra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read data; hold it when no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bfra_run_track.sv
// Free-run tracker: while step is set, folds one slice of free bits per cycle
// into the current run and the chosen candidate. Depends on bfra_pkg.
module bfra_run_track #(
  parameter int unsigned PW = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfra_pkg::trk_ctrl_t             ctrl_i,
  input  logic [bfra_pkg::SLICE_W-1:0]    free_i,
  input  logic [PW-1:0]                   base_i,
  output logic                            have_o,
  output logic [PW-1:0]                   best_start_o
);
  import bfra_pkg::*;

  localparam logic [PW:0] LEN_ONE = (PW+1)'(1);

  logic [PW:0]   run_len_q, run_len_d;
  logic [PW-1:0] run_start_q, run_start_d;
  logic [PW:0]   best_len_q, best_len_d;
  logic [PW-1:0] best_start_q, best_start_d;
  logic          have_q, have_d;

  // Walk the slice bit by bit; a used bit closes the open run
  always_comb begin
    logic take;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    have_d       = have_q;
    take         = 1'b0;
    for (int k = 0; k < SLICE_W; k++) begin
      if (free_i[k]) begin
        if (run_len_d == '0) begin
          run_start_d = base_i | PW'(k);
        end
        run_len_d = run_len_d + LEN_ONE;
      end else if (run_len_d != '0) begin
        take = !have_d || (ctrl_i.best && (run_len_d < best_len_d))
                       || (ctrl_i.worst && (run_len_d > best_len_d));
        if (take) begin
          best_start_d = run_start_d;
          best_len_d   = run_len_d;
          have_d       = 1'b1;
        end
        run_len_d = '0;
      end
    end
  end

  // Clear at the start of a search, advance on each slice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q    <= '0;
      run_start_q  <= '0;
      best_len_q   <= '0;
      best_start_q <= '0;
      have_q       <= 1'b0;
    end else if (ctrl_i.clear) begin
      run_len_q    <= '0;
      best_len_q   <= '0;
      have_q       <= 1'b0;
    end else if (ctrl_i.step) begin
      run_len_q    <= run_len_d;
      run_start_q  <= run_start_d;
      best_len_q   <= best_len_d;
      best_start_q <= best_start_d;
      have_q       <= have_d;
    end
  end

  assign have_o       = have_q;
  assign best_start_o = best_start_q;

  // A candidate always has a nonzero length
  a_have_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> best_len_q != '0)
    else $error("candidate held with zero length");

  // Clearing drops the candidate and the open run
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> !have_q && run_len_q == '0)
    else $error("tracker not cleared");

  // Best fit never trades a candidate for a longer one
  a_best_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && !ctrl_i.clear && ctrl_i.best && have_q
      |=> best_len_q <= $past(best_len_q))
    else $error("best fit candidate grew");

endmodule

FILE: hdl/bitmap_free_run_allocator.sv
// Top level of the bitmap free-run allocator: request sequencer, bitmap RAM
// and run tracker. Depends on bfra_pkg, bfra_ram and bfra_run_track.
//
// Both usage maps live in one RAM of 32-bit rows, the inode map in the lower
// half and the block map in the upper half. After reset the block sweeps the
// RAM to all-free, one row per cycle, with busy_o high; configuration writes
// are taken meanwhile. A request is taken when start_i is high and busy_o
// low. A write is a read-modify-write of one row, and its acknowledge strobes
// on done_o after the row is written back and the result state is passed (an
// index past the map skips the row update). A search reads the selected map
// row by row and the run tracker folds 8 bits per cycle, so it strobes done_o
// once the searched count has been scanned. done_o holds for exactly one
// cycle and cannot be held off; found_o and start_index_o are valid in that
// cycle and hold until the next result. busy_o is low in that cycle, so a new
// request may be given then.
module bitmap_free_run_allocator #(
  parameter int unsigned MAP_ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfra_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic                          map_select_i,
  input  logic [bfra_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic                          entry_used_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [bfra_pkg::START_W-1:0]  start_index_o
);
  import bfra_pkg::*;

  localparam int unsigned WORDS = (MAP_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned RAW   = WAW + 1;
  localparam int unsigned ROWS  = 2 << WAW;
  localparam int unsigned PW    = WAW + WORD_AW;
  localparam int unsigned XW    = ((PW + 1) > CFG_W) ? (PW + 1) : CFG_W;
  localparam logic [XW-1:0] ENTRIES_X = XW'(MAP_ENTRIES);
  localparam logic [SLICE_SEL_W-1:0] SLICE_LAST = '1;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WMOD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [1:0]             fit_mode_q;
  logic [CFG_W-1:0]       inode_entries_q, block_entries_q;
  logic [RAW-1:0]         clr_q;
  logic [RAW-1:0]         row_q;
  logic [WORD_AW-1:0]     bit_q;
  logic                   used_q;
  logic                   op_q;
  logic                   sel_q;
  logic [PW:0]            cnt_q;
  logic [WAW-1:0]         word_q;
  logic [SLICE_SEL_W-1:0] slice_q;
  logic                   done_q, found_q;
  logic [START_W-1:0]     start_q;

  logic                   accept;
  logic [XW-1:0]          cfg_cnt_x, idx_x;
  logic [PW:0]            eff_cnt;
  logic                   idx_ok;
  logic [RAW-1:0]         acc_row;
  logic [PW:0]            cnt_m1;
  logic [WAW-1:0]         last_word;
  logic                   scan_last;
  logic                   ram_we, ram_re;
  logic [RAW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]      ram_wdata, ram_rdata;
  logic [SLICE_W-1:0]     slice_bits, free_bits;
  logic [PW-1:0]          slice_base;
  trk_ctrl_t              trk_ctrl;
  logic                   trk_have;
  logic [PW-1:0]          trk_start;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Saturate the searched count to the map size
  assign cfg_cnt_x = XW'(map_select_i ? block_entries_q : inode_entries_q);
  assign eff_cnt   = (PW+1)'((cfg_cnt_x > ENTRIES_X) ? ENTRIES_X : cfg_cnt_x);

  // Row of the written entry, or row 0 of the map for a search
  assign idx_x   = XW'(entry_index_i);
  assign idx_ok  = idx_x < ENTRIES_X;
  assign acc_row = (operation_i == OP_WRITE) ? {map_select_i, idx_x[PW-1:WORD_AW]}
                                             : {map_select_i, {WAW{1'b0}}};

  assign cnt_m1    = cnt_q - (PW+1)'(1);
  assign last_word = cnt_m1[PW-1:WORD_AW];
  assign scan_last = (slice_q == SLICE_LAST) && (word_q == last_word);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q      <= FIT_FIRST;
      inode_entries_q <= CFG_W'(1024);
      block_entries_q <= CFG_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIT_MODE:      fit_mode_q      <= cfg_wdata_i[1:0];
        REG_INODE_ENTRIES: inode_entries_q <= cfg_wdata_i;
        REG_BLOCK_ENTRIES: block_entries_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_WRITE) begin
            state_d = idx_ok ? S_WMOD : S_RES;
          end else begin
            state_d = (eff_cnt == '0) ? S_FIN : S_SCAN;
          end
        end
      end
      S_WMOD: state_d = S_RES;
      S_SCAN: if (scan_last) state_d = S_FIN;
      S_FIN:  state_d = S_RES;
      S_RES:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      word_q  <= '0;
      slice_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_RES);
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + RAW'(1);
      end
      if (accept) begin
        word_q  <= '0;
        slice_q <= '0;
      end else if (state_q == S_SCAN) begin
        slice_q <= slice_q + SLICE_SEL_W'(1);
        if (slice_q == SLICE_LAST) begin
          word_q <= word_q + WAW'(1);
        end
      end
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      sel_q  <= map_select_i;
      row_q  <= acc_row;
      bit_q  <= entry_index_i[WORD_AW-1:0];
      used_q <= entry_used_i;
      cnt_q  <= eff_cnt;
    end
    if (state_q == S_RES) begin
      found_q <= (op_q == OP_WRITE) ? 1'b1 : trk_have;
      start_q <= ((op_q == OP_SEARCH) && trk_have) ? START_W'(trk_start) : '0;
    end
  end

  // RAM ports: sweep, read-modify-write, and the row-by-row scan
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WMOD);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : row_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0
                   : ((ram_rdata & ~(WORD_W'(1) << bit_q)) | (WORD_W'(used_q) << bit_q));
  assign ram_re    = accept || ((state_q == S_SCAN) && (slice_q == SLICE_LAST));
  assign ram_raddr = (state_q == S_IDLE) ? acc_row : {sel_q, word_q + WAW'(1)};

  bfra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Free bits of the current slice; entries past the count count as used
  assign slice_bits = ram_rdata[slice_q*SLICE_W +: SLICE_W];
  assign slice_base = {word_q, slice_q, {SLICE_AW{1'b0}}};

  always_comb begin
    free_bits = '0;
    if (state_q == S_SCAN) begin
      for (int k = 0; k < SLICE_W; k++) begin
        free_bits[k] = !slice_bits[k] && ({1'b0, (slice_base | PW'(k))} < cnt_q);
      end
    end
  end

  // A step with no free bits in the final state closes a trailing run
  assign trk_ctrl.clear = accept;
  assign trk_ctrl.step  = (state_q == S_SCAN) || (state_q == S_FIN);
  assign trk_ctrl.best  = (fit_mode_q == FIT_BEST);
  assign trk_ctrl.worst = (fit_mode_q == FIT_WORST);

  bfra_run_track #(
    .PW (PW)
  ) u_run_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (trk_ctrl),
    .free_i       (free_bits),
    .base_i       (slice_base),
    .have_o       (trk_have),
    .best_start_o (trk_start)
  );

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign start_index_o = start_q;

  // The strobe follows the result state and lasts one cycle
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_RES) && !$past(done_q))
    else $error("result strobe without result state");

  // Writes are always acknowledged with start zero
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (op_q == OP_WRITE) |-> found_q && (start_q == '0))
    else $error("bad write acknowledge");

  // The scan never runs past the last row of the searched count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q != '0) && (word_q <= last_word))
    else $error("scan past the searched count");

endmodule
